>>> hw/rtl/ldpchd_pkg.sv
package ldpchd_pkg;

  localparam int InDataW  = 136;  // row_index, row_bits, received_word, padded
  localparam int OutDataW = 72;   // decoded_word, iterations_used, converged, padded
  localparam int FieldW   = 64;
  localparam int IterW    = 4;
  localparam int ChecksW  = 6;
  localparam int BitsW    = 7;
  localparam int IdxW     = 5;
  localparam int PaddrW   = 4;
  localparam int PdataW   = 32;

  localparam logic OP_ROW    = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [1:0] REG_CHECKS = 2'd0;
  localparam logic [1:0] REG_BITS   = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_VAR,
    ST_EST,
    ST_DECIDE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic start;     // latch received word, begin a decode
    logic clr;       // clear per-column degree and sum counters
    logic chk;       // row read issued in check phase
    logic var_ph;    // row read issued in variable phase
    logic est;       // form estimate and compare
    logic load_out;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic conv;
  } stat_t;

endpackage

>>> hw/rtl/ldpc_hard_decision_decoder.sv
// Hard-decision message-passing LDPC decoder. Load parity-check rows first
// (tuser op 0, one row per transfer, no result), then send a received word
// (op 1); one result transfer follows with the decoded word, the iteration
// count and a converged flag. Rows, variable-to-check and check-to-variable
// messages live in three RAMs with one read port each, walked one row per
// cycle. Each iteration is a check pass and a variable pass over the rows in
// use, then estimate and decide. Inputs are taken only between decodes; a
// finished result waits in an output register while the next transfer is
// accepted. Registers: 0x0 active_checks, 0x4 active_bits, 0x8 iteration_limit;
// write only while idle.
module ldpc_hard_decision_decoder #(
  parameter int MAX_BITS   = 64,
  parameter int MAX_CHECKS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [4:0] row_index, [68:5] row_bits, [132:69] received_word, rest zero
  input  logic [ldpchd_pkg::InDataW-1:0]     in_tdata,
  // [0] op
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [63:0] decoded_word, [67:64] iterations_used, [68] converged, rest zero
  output logic [ldpchd_pkg::OutDataW-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ldpchd_pkg::PaddrW-1:0]      cfg_paddr,
  input  logic [ldpchd_pkg::PdataW-1:0]      cfg_pwdata,
  output logic [ldpchd_pkg::PdataW-1:0]      cfg_prdata,
  output logic                               cfg_pready
);
  import ldpchd_pkg::*;

  localparam int AW = $clog2(MAX_CHECKS > 1 ? MAX_CHECKS : 2);
  localparam int CW = $clog2(MAX_CHECKS + 1);
  localparam int BW = $clog2(MAX_BITS + 1);

  logic [ChecksW-1:0] checks_r;
  logic [BitsW-1:0]   bits_r;
  logic [IterW-1:0]   limit_r;
  logic               cfg_wr;

  logic [CW-1:0]      nc;
  logic [BW-1:0]      nb;
  logic [IterW-1:0]   lim_eff;

  cmd_t               cmd;
  stat_t              stat;
  logic [AW-1:0]      rd_addr;
  logic [IterW-1:0]   iter;
  logic               in_xfer;
  logic               row_we;
  logic [IdxW-1:0]    in_idx;
  logic [MAX_BITS-1:0] out_word;
  logic [IterW-1:0]   out_iter;
  logic               out_conv;

  // config registers, full pready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checks_r <= ChecksW'(32);
      bits_r   <= BitsW'(64);
      limit_r  <= IterW'(10);
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_CHECKS: checks_r <= cfg_pwdata[ChecksW-1:0];
        REG_BITS:   bits_r   <= cfg_pwdata[BitsW-1:0];
        REG_LIMIT:  limit_r  <= cfg_pwdata[IterW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_CHECKS: cfg_prdata = PdataW'(checks_r);
      REG_BITS:   cfg_prdata = PdataW'(bits_r);
      REG_LIMIT:  cfg_prdata = PdataW'(limit_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // effective sizes: saturate at the built store, zero limit runs once
  assign nc      = (checks_r > MAX_CHECKS) ? CW'(MAX_CHECKS) : CW'(checks_r);
  assign nb      = (bits_r > MAX_BITS) ? BW'(MAX_BITS) : BW'(bits_r);
  assign lim_eff = (limit_r == '0) ? IterW'(1) : limit_r;

  // row store writes; rows beyond the store are dropped
  assign in_xfer = in_tvalid && in_tready;
  assign in_idx  = in_tdata[IdxW-1:0];
  assign row_we  = in_xfer && in_tuser == OP_ROW && int'(in_idx) < MAX_CHECKS;

  ldpchd_ctrl #(.MAX_CHECKS(MAX_CHECKS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_op(in_tuser), .in_tready(in_tready),
    .out_tready(out_tready), .out_tvalid(out_tvalid),
    .nc(nc), .limit(lim_eff), .stat(stat),
    .cmd(cmd), .rd_addr(rd_addr), .iter(iter)
  );

  ldpchd_dpath #(.MAX_BITS(MAX_BITS), .MAX_CHECKS(MAX_CHECKS)) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .rd_addr(rd_addr),
    .row_we(row_we), .row_idx(AW'(in_idx)),
    .row_bits(in_tdata[IdxW +: MAX_BITS]),
    .in_word(in_tdata[IdxW + FieldW +: MAX_BITS]),
    .nb(nb), .iter(iter), .stat(stat),
    .out_word(out_word), .out_iter(out_iter), .out_conv(out_conv)
  );

  assign out_tdata = {3'b000, out_conv, out_iter, FieldW'(out_word)};

endmodule

>>> hw/rtl/ldpchd_ram.sv
module ldpchd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ldpchd_ctrl.sv
module ldpchd_ctrl #(
  parameter int MAX_CHECKS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_op,
  output logic                      in_tready,
  input  logic                      out_tready,
  output logic                      out_tvalid,
  input  logic [$clog2(MAX_CHECKS+1)-1:0] nc,
  input  logic [ldpchd_pkg::IterW-1:0] limit,
  input  ldpchd_pkg::stat_t         stat,
  output ldpchd_pkg::cmd_t          cmd,
  output logic [$clog2(MAX_CHECKS > 1 ? MAX_CHECKS : 2)-1:0] rd_addr,
  output logic [ldpchd_pkg::IterW-1:0] iter
);
  import ldpchd_pkg::*;

  localparam int CW = $clog2(MAX_CHECKS + 1);
  localparam int AW = $clog2(MAX_CHECKS > 1 ? MAX_CHECKS : 2);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [IterW-1:0] it_r, it_nxt;
  logic            ov_r, ov_nxt;
  logic            more;

  assign more = cnt_r < nc;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    it_nxt    = it_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_op == OP_DECODE) begin
          state_nxt = ST_CHECK;
          cnt_nxt   = '0;
          it_nxt    = '0;
        end
      end
      ST_CHECK, ST_VAR: begin
        if (more) begin
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_CHECK) ? ST_VAR : ST_EST;
        end
      end
      ST_EST: begin
        it_nxt    = it_r + IterW'(1);
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = (stat.conv || it_r == limit) ? ST_FIN : ST_CHECK;
      end
      ST_FIN: begin
        if (!ov_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    in_tready    = 1'b0;
    cmd.start    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid && in_op == OP_DECODE;
      end
      ST_CHECK: begin
        cmd.clr = (cnt_r == '0);
        cmd.chk = more;
      end
      ST_VAR:    cmd.var_ph   = more;
      ST_EST:    cmd.est      = 1'b1;
      ST_FIN:    cmd.load_out = !ov_r || out_tready;
      default:   cmd          = '0;
    endcase
  end

  assign ov_nxt     = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : ov_r);
  assign out_tvalid = ov_r;
  assign rd_addr    = cnt_r[AW-1:0];
  assign iter       = it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      it_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      it_r    <= it_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.chk || cmd.var_ph) |-> (cnt_r < nc))
    else $error("row read beyond rows in use");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |-> (it_r <= limit && it_r != '0))
    else $error("iteration count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!ov_r || out_tready))
    else $error("result overwritten before transfer");

  a_conv_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && stat.conv) |=> (state_r == ST_FIN))
    else $error("converged decode did not stop");

endmodule

>>> hw/rtl/ldpchd_dpath.sv
module ldpchd_dpath #(
  parameter int MAX_BITS   = 64,
  parameter int MAX_CHECKS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ldpchd_pkg::cmd_t          cmd,
  input  logic [$clog2(MAX_CHECKS > 1 ? MAX_CHECKS : 2)-1:0] rd_addr,
  input  logic                      row_we,
  input  logic [$clog2(MAX_CHECKS > 1 ? MAX_CHECKS : 2)-1:0] row_idx,
  input  logic [MAX_BITS-1:0]       row_bits,
  input  logic [MAX_BITS-1:0]       in_word,
  input  logic [$clog2(MAX_BITS+1)-1:0] nb,
  input  logic [ldpchd_pkg::IterW-1:0] iter,
  output ldpchd_pkg::stat_t         stat,
  output logic [MAX_BITS-1:0]       out_word,
  output logic [ldpchd_pkg::IterW-1:0] out_iter,
  output logic                      out_conv
);
  import ldpchd_pkg::*;

  localparam int NB = MAX_BITS;
  localparam int AW = $clog2(MAX_CHECKS > 1 ? MAX_CHECKS : 2);
  localparam int BW = $clog2(MAX_BITS + 1);
  localparam int DW = $clog2(MAX_CHECKS + 1);

  logic [NB-1:0] colmask;
  logic [NB-1:0] recv_r, est_r, prev_r;
  logic          first_r, pv_r, conv_r;
  logic          chk_d_r, var_d_r;
  logic [AW-1:0] addr_d_r;
  logic [DW-1:0] deg_r [NB];
  logic [DW-1:0] sum_r [NB];

  logic [NB-1:0] row_q, v2c_q, c2v_q;
  logic [NB-1:0] row_m, chk_in, c2v_new, v2c_new, est_new;

  ldpchd_ram #(.WIDTH(NB), .DEPTH(MAX_CHECKS)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_idx), .wdata(row_bits),
    .raddr(rd_addr), .rdata(row_q)
  );

  ldpchd_ram #(.WIDTH(NB), .DEPTH(MAX_CHECKS)) u_v2c (
    .clk(clk), .we(var_d_r), .waddr(addr_d_r), .wdata(v2c_new),
    .raddr(rd_addr), .rdata(v2c_q)
  );

  ldpchd_ram #(.WIDTH(NB), .DEPTH(MAX_CHECKS)) u_c2v (
    .clk(clk), .we(chk_d_r), .waddr(addr_d_r), .wdata(c2v_new),
    .raddr(rd_addr), .rdata(c2v_q)
  );

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      colmask[j] = BW'(j) < nb;
    end
  end

  // check phase: c2v = XOR of the other incoming bits on the row
  assign row_m   = row_q & colmask;
  assign chk_in  = (first_r ? recv_r : v2c_q) & row_m;
  assign c2v_new = (^chk_in) ? (~chk_in & row_m) : chk_in;

  // variable phase and estimate, one lane per column
  always_comb begin
    logic [DW-1:0] other;
    logic [DW:0]   tot;
    logic [DW:0]   tot2;
    for (int j = 0; j < NB; j++) begin
      other      = sum_r[j] - DW'(c2v_q[j]);
      tot        = {1'b0, other} + (DW+1)'(recv_r[j]);
      v2c_new[j] = row_m[j] && ({tot, 1'b0} >= {2'b00, deg_r[j]});
      tot2       = {1'b0, sum_r[j]} + (DW+1)'(recv_r[j]);
      est_new[j] = {tot2, 1'b0} >= ({2'b00, deg_r[j]} + (DW+2)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_d_r <= 1'b0;
      var_d_r <= 1'b0;
      first_r <= 1'b0;
      pv_r    <= 1'b0;
      conv_r  <= 1'b0;
    end else begin
      chk_d_r <= cmd.chk;
      var_d_r <= cmd.var_ph;
      if (cmd.start) begin
        first_r <= 1'b1;
        pv_r    <= 1'b0;
        conv_r  <= 1'b0;
      end else if (cmd.est) begin
        first_r <= 1'b0;
        pv_r    <= 1'b1;
        conv_r  <= pv_r && (est_new == prev_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_d_r <= rd_addr;
    if (cmd.start) begin
      recv_r <= in_word & colmask;
    end
    if (cmd.est) begin
      est_r  <= est_new;
      prev_r <= est_new;
    end
    if (cmd.load_out) begin
      out_word <= est_r;
      out_iter <= iter;
      out_conv <= conv_r;
    end
    for (int j = 0; j < NB; j++) begin
      if (cmd.clr) begin
        deg_r[j] <= '0;
        sum_r[j] <= '0;
      end else if (chk_d_r) begin
        deg_r[j] <= deg_r[j] + DW'(row_m[j]);
        sum_r[j] <= sum_r[j] + DW'(c2v_new[j]);
      end
    end
  end

  assign stat.conv = conv_r;

endmodule

>>> tb/sv/ldpchd_checker.sv
// Watches the row/word input stream, the result stream and the register port.
// Keeps its own copy of the row store and the registers, predicts each decode
// and compares results in order.
module ldpchd_checker
  import ldpchd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [PaddrW-1:0]   cfg_paddr,
  input  logic [PdataW-1:0]   cfg_pwdata,
  input  logic                cfg_pready,
  output int                  fail_count,
  output int                  results_owed,
  output int                  decodes_checked
);

  typedef struct {
    logic [63:0] word;
    logic [3:0]  iters;
    logic        conv;
  } decode_result_t;

  logic [63:0] row_store [32];
  logic [5:0]  num_checks;
  logic [6:0]  num_bits;
  logic [3:0]  iter_limit;
  decode_result_t owed_q[$];

  function automatic decode_result_t hard_decode(input logic [63:0] word);
    decode_result_t res;
    int nc, nb, lim, deg, sum, other, rb;
    logic [63:0] colmask, rcv, est, est_prev, parity_in;
    logic [63:0] rows [32];
    logic [63:0] v2c [32];
    logic [63:0] c2v [32];
    bit prev_ok, done;
    nc = (num_checks > 32) ? 32 : num_checks;
    nb = (num_bits > 64) ? 64 : num_bits;
    lim = (iter_limit == 0) ? 1 : iter_limit;
    colmask = (nb >= 64) ? '1 : ((64'd1 << nb) - 64'd1);
    rcv = word & colmask;
    for (int i = 0; i < 32; i++) begin
      rows[i] = (i < nc) ? (row_store[i] & colmask) : '0;
      v2c[i] = rows[i] & rcv;
      c2v[i] = '0;
    end
    est = '0;
    est_prev = '0;
    prev_ok = 0;
    done = 0;
    res.iters = '0;
    for (int it = 0; it < lim && !done; it++) begin
      for (int i = 0; i < nc; i++) begin
        parity_in = v2c[i] & rows[i];
        c2v[i] = (^parity_in) ? (~parity_in & rows[i]) : parity_in;
      end
      est = '0;
      for (int j = 0; j < nb; j++) begin
        rb = rcv[j];
        deg = 0;
        sum = 0;
        for (int i = 0; i < nc; i++)
          if (rows[i][j]) begin
            deg++;
            sum += c2v[i][j];
          end
        for (int i = 0; i < nc; i++)
          if (rows[i][j]) begin
            other = sum - c2v[i][j];
            v2c[i][j] = (2 * (rb + other) >= deg);
          end
        if (2 * (rb + sum) >= deg + 1) est[j] = 1'b1;
      end
      res.iters = 4'(it + 1);
      if (prev_ok && est == est_prev) done = 1;
      else begin
        est_prev = est;
        prev_ok = 1;
      end
    end
    res.word = est & colmask;
    res.conv = done;
    return res;
  endfunction

  assign results_owed = owed_q.size();

  always @(posedge clk) begin
    decode_result_t exp_r;
    if (!rst_n) begin
      num_checks <= 6'd32;
      num_bits <= 7'd64;
      iter_limit <= 4'd10;
      fail_count <= 0;
      decodes_checked <= 0;
      owed_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_CHECKS: num_checks <= cfg_pwdata[5:0];
          REG_BITS:   num_bits <= cfg_pwdata[6:0];
          REG_LIMIT:  iter_limit <= cfg_pwdata[3:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_ROW) row_store[in_tdata[4:0]] = in_tdata[68:5];
        else owed_q.insert(owed_q.size(), hard_decode(in_tdata[132:69]));
      end
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          $error("result transfer with no decode pending");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = owed_q.pop_front();
          decodes_checked <= decodes_checked + 1;
          if (out_tdata[63:0] !== exp_r.word) begin
            $error("decoded_word exp %h got %h", exp_r.word, out_tdata[63:0]);
            fail_count <= fail_count + 1;
          end
          if (out_tdata[67:64] !== exp_r.iters) begin
            $error("iterations_used exp %0d got %0d", exp_r.iters, out_tdata[67:64]);
            fail_count <= fail_count + 1;
          end
          if (out_tdata[68] !== exp_r.conv) begin
            $error("converged exp %0b got %0b", exp_r.conv, out_tdata[68]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/tb.sv
// Top of the decoder bench: clock, reset, stimulus and verdict. All checking
// sits in ldpchd_checker.
module tb;
  import ldpchd_pkg::*;

  localparam longint CycleLimit = 6000000;
  localparam int DrainCycles = 1200;  // covers the worst decode: 32 rows, limit 15

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [PaddrW-1:0] cfg_paddr = '0;
  logic [PdataW-1:0] cfg_pwdata = '0;
  logic [PdataW-1:0] cfg_prdata;
  logic cfg_pready;

  int fail_count, results_owed, decodes_checked;
  int row_writes = 0;
  longint cycles = 0;
  bit [31:0] rows_loaded = '0;  // rows written so far; a decode never reads others
  bit rx_hold = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ldpc_hard_decision_decoder u_top (.*);

  ldpchd_checker u_chk (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: errors");
      $finish;
    end
  end

  // result side back-pressure; some phases hold tready high throughout
  int stall_left = 0;
  always @(posedge clk) begin
    if (rx_hold) out_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_tready && out_tvalid && $urandom_range(0, 2) == 0) begin
      stall_left <= gap_len();
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  task automatic send(input logic op, input logic [4:0] idx, input logic [63:0] rowv,
                      input logic [63:0] word, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b0, word, rowv, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_ROW) begin
      row_writes++;
      rows_loaded[idx] = 1'b1;
    end
  endtask

  task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // drop tvalid, let results drain, then let any trailing row write settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [63:0] sparse_row();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
  endfunction

  task automatic configure(input int nc, input int nb, input int lim);
    int used;
    quiesce();
    reg_write(REG_CHECKS, nc);
    reg_write(REG_BITS, nb);
    reg_write(REG_LIMIT, lim);
    used = (nc > 32) ? 32 : nc;
    for (int i = 0; i < used; i++)
      if (!rows_loaded[i]) send(OP_ROW, 5'(i), sparse_row(), '0, 1);
  endtask

  // received word: near all-zeros or all-ones, or plain noise
  function automatic logic [63:0] rx_word();
    logic [63:0] w;
    case ($urandom_range(0, 3))
      0: w = {$urandom, $urandom};
      1: w = '1;
      default: w = '0;
    endcase
    repeat ($urandom_range(0, 4)) w[$urandom_range(0, 63)] ^= 1'b1;
    return w;
  endfunction

  task automatic random_phase(input int nc, input int nb, input int lim, input int n);
    int used;
    configure(nc, nb, lim);
    rx_hold = ($urandom_range(0, 3) == 0);
    used = (nc > 32) ? 32 : nc;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 30)
        send(OP_ROW, 5'($urandom_range(0, 31)), sparse_row(), {$urandom, $urandom}, 1);
      else
        send(OP_DECODE, 5'($urandom), {$urandom, $urandom}, rx_word(), 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: four rows with extreme patterns, then extreme words
    configure(4, 64, 10);
    send(OP_ROW, 5'd0, '1, '0, 0);
    send(OP_ROW, 5'd1, 64'h0000_0000_0000_0003, '1, 0);
    send(OP_ROW, 5'd2, 64'h8000_0000_0000_0001, '0, 0);
    send(OP_ROW, 5'd3, '0, '0, 0);  // an empty row: adds to no column's degree
    send(OP_DECODE, 5'd31, '1, '0, 0);
    send(OP_DECODE, 5'd0, '0, '1, 0);
    send(OP_DECODE, 5'd0, '0, 64'h8000_0000_0000_0001, 0);
    send(OP_DECODE, 5'd0, '0, 64'h5555_5555_5555_5555, 1);
    send(OP_ROW, 5'd31, {$urandom, $urandom}, '0, 1);  // top row index
    // single-column code, single iteration
    configure(1, 1, 1);
    send(OP_DECODE, 5'd0, '0, '1, 0);
    send(OP_DECODE, 5'd0, '0, 64'hFFFF_FFFF_FFFF_FFFE, 0);
    // out-of-range register values: saturation and limit zero
    configure(63, 127, 0);
    send(OP_DECODE, 5'd0, '0, {$urandom, $urandom}, 0);
    configure(0, 0, 15);
    send(OP_DECODE, 5'd0, '0, '1, 0);

    random_phase(32, 64, 15, 40);
    random_phase(1, 1, 1, 80);
    random_phase(63, 127, 0, 30);
    random_phase(0, 2, 3, 60);
    for (int p = 0; p < 10; p++)
      random_phase($urandom_range(1, 8), $urandom_range(2, 64), $urandom_range(1, 15), 130);
    random_phase($urandom_range(9, 32), $urandom_range(1, 64), $urandom_range(1, 15), 40);
    random_phase(3, 64, 15, 40);

    quiesce();
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d row writes and %0d checked decodes over many register settings",
             row_writes, decodes_checked);
    $display("including register extremes, zero checks, zero bits and limit zero");
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
